/* rtl/cst_pkg.sv */
package cst_pkg;

    localparam int POS_BITS_DEF = 24;
    localparam int OUT_POS      = 24;
    localparam int KW_LEN       = 8;
    localparam int KW_COUNT     = 29;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_AW      = 3;
    localparam int FIFO_ROOM    = FIFO_DEPTH - 3;

    localparam logic [3:0] K_EOF     = 4'd0;
    localparam logic [3:0] K_INVALID = 4'd1;
    localparam logic [3:0] K_KEYWORD = 4'd2;
    localparam logic [3:0] K_NAME    = 4'd3;
    localparam logic [3:0] K_INT     = 4'd4;
    localparam logic [3:0] K_FLOAT   = 4'd5;
    localparam logic [3:0] K_CHAR    = 4'd6;
    localparam logic [3:0] K_STRING  = 4'd7;
    localparam logic [3:0] K_BOOL    = 4'd8;
    localparam logic [3:0] K_PUNCT   = 4'd9;
    localparam logic [3:0] K_OP      = 4'd10;
    localparam logic [3:0] K_VARARGS = 4'd11;

    localparam logic [3:0] CL_I   = 4'd0;
    localparam logic [3:0] CL_U   = 4'd1;
    localparam logic [3:0] CL_L   = 4'd2;
    localparam logic [3:0] CL_UL  = 4'd3;
    localparam logic [3:0] CL_LL  = 4'd4;
    localparam logic [3:0] CL_ULL = 4'd5;
    localparam logic [3:0] CL_F   = 4'd6;
    localparam logic [3:0] CL_DB  = 4'd7;
    localparam logic [3:0] CL_LDB = 4'd8;

    typedef enum logic [25:0] {
        M_IDLE     = 26'd1 << 0,
        M_NAME     = 26'd1 << 1,
        M_ZERO     = 26'd1 << 2,
        M_DEC      = 26'd1 << 3,
        M_OCT      = 26'd1 << 4,
        M_HEX0     = 26'd1 << 5,
        M_HEX      = 26'd1 << 6,
        M_DOT      = 26'd1 << 7,
        M_FRAC     = 26'd1 << 8,
        M_EXP0     = 26'd1 << 9,
        M_EXP      = 26'd1 << 10,
        M_SUF_U    = 26'd1 << 11,
        M_SUF_UL   = 26'd1 << 12,
        M_SUF_L    = 26'd1 << 13,
        M_SUF_FL   = 26'd1 << 14,
        M_TAIL     = 26'd1 << 15,
        M_BAD      = 26'd1 << 16,
        M_CH_OPEN  = 26'd1 << 17,
        M_CH_ESC   = 26'd1 << 18,
        M_CH_CLOSE = 26'd1 << 19,
        M_STR      = 26'd1 << 20,
        M_STR_ESC  = 26'd1 << 21,
        M_OP1      = 26'd1 << 22,
        M_OP2      = 26'd1 << 23,
        M_DOT1     = 26'd1 << 24,
        M_DOT2     = 26'd1 << 25
    } mode_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [7:0]         subcode;
        logic [31:0]        value;
        logic               overflow;
        logic [OUT_POS-1:0] start_pos;
        logic [OUT_POS-1:0] length;
    } res_t;

    // words right-aligned, first character in the highest used byte
    localparam logic [63:0] KW_WORDS [KW_COUNT] = '{
        "long", "int", "short", "char", "unsigned", "double", "float", "void",
        "do", "while", "continue", "break", "for", "switch", "case", "default",
        "if", "else", "goto", "return", "extern", "inline", "const", "static",
        "struct", "union", "enum", "typedef", "sizeof"
    };

    function automatic logic [5:0] kw_lookup(logic [63:0] w);
        logic [5:0] r;
        r = '0;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            if (w == KW_WORDS[i])
            begin
                r = {1'b1, 5'(i)};
            end
        end
        return r;
    endfunction

    // key holds up to three operator bytes, unused ones zero
    function automatic logic [6:0] op_lookup(logic [23:0] key);
        logic [6:0] r;
        case (key)
            {"&&", 8'h00}: r = {1'b1, 6'd0};
            {"->", 8'h00}: r = {1'b1, 6'd1};
            {"&", 16'h0}:  r = {1'b1, 6'd2};
            {"|", 16'h0}:  r = {1'b1, 6'd3};
            {"^", 16'h0}:  r = {1'b1, 6'd4};
            {"/", 16'h0}:  r = {1'b1, 6'd5};
            {".", 16'h0}:  r = {1'b1, 6'd6};
            {"==", 8'h00}: r = {1'b1, 6'd7};
            {">=", 8'h00}: r = {1'b1, 6'd8};
            {">", 16'h0}:  r = {1'b1, 6'd9};
            {"*", 16'h0}:  r = {1'b1, 6'd10};
            {"!=", 8'h00}: r = {1'b1, 6'd11};
            {"!", 16'h0}:  r = {1'b1, 6'd12};
            {"||", 8'h00}: r = {1'b1, 6'd13};
            {"+", 16'h0}:  r = {1'b1, 6'd14};
            {"<=", 8'h00}: r = {1'b1, 6'd15};
            {"<<", 8'h00}: r = {1'b1, 6'd16};
            {">>", 8'h00}: r = {1'b1, 6'd17};
            {"<", 16'h0}:  r = {1'b1, 6'd18};
            {"-", 16'h0}:  r = {1'b1, 6'd19};
            {"=", 16'h0}:  r = {1'b1, 6'd20};
            {"%", 16'h0}:  r = {1'b1, 6'd21};
            {"?", 16'h0}:  r = {1'b1, 6'd22};
            {":", 16'h0}:  r = {1'b1, 6'd23};
            {"~", 16'h0}:  r = {1'b1, 6'd24};
            {"++", 8'h00}: r = {1'b1, 6'd25};
            {"--", 8'h00}: r = {1'b1, 6'd26};
            {"+=", 8'h00}: r = {1'b1, 6'd27};
            {"-=", 8'h00}: r = {1'b1, 6'd28};
            {"*=", 8'h00}: r = {1'b1, 6'd29};
            {"/=", 8'h00}: r = {1'b1, 6'd30};
            {"%=", 8'h00}: r = {1'b1, 6'd31};
            {"&=", 8'h00}: r = {1'b1, 6'd32};
            {"|=", 8'h00}: r = {1'b1, 6'd33};
            {"^=", 8'h00}: r = {1'b1, 6'd34};
            "<<=":         r = {1'b1, 6'd35};
            ">>=":         r = {1'b1, 6'd36};
            default:       r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] escape_val(logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h5c:   r = {1'b1, 8'd92};
            8'h27:   r = {1'b1, 8'd39};
            8'h22:   r = {1'b1, 8'd34};
            "a":     r = {1'b1, 8'd7};
            "b":     r = {1'b1, 8'd8};
            "f":     r = {1'b1, 8'd12};
            "n":     r = {1'b1, 8'd10};
            "r":     r = {1'b1, 8'd13};
            "t":     r = {1'b1, 8'd9};
            "v":     r = {1'b1, 8'd11};
            "0":     r = {1'b1, 8'd0};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic pair_ok(logic [7:0] a, logic [7:0] b);
        logic r;
        case (a)
            "&":     r = (b == "&") || (b == "=");
            "|":     r = (b == "|") || (b == "=");
            "+":     r = (b == "+") || (b == "=");
            "-":     r = (b == ">") || (b == "-") || (b == "=");
            ">":     r = (b == ">") || (b == "=");
            "<":     r = (b == "<") || (b == "=");
            default: r = (b == "=");
        endcase
        return r;
    endfunction

endpackage

/* rtl/c_source_tokenizer.sv */
// c source tokenizer, maximal munch
// input stream: one source byte per beat in s_tdata[7:0]; a beat with s_tlast
// high is the end of text (s_tdata ignored): the pending token is flushed, an
// eof token follows and all lexer state returns to reset, so the next byte
// starts a new text at offset 0
// output stream: one token per beat, kind in m_tuser, the rest in m_tdata
// a byte beat yields zero to three tokens, an end-of-text beat one to three;
// a token is finished by the byte after it, unless its own last byte closes it
// throughput: one beat per cycle while s_tready is high; each beat is lexed by
// the combinational state update logic and its tokens are written into an
// 8-entry result queue on the clock edge that takes the beat; the queue hands
// them out in order, one per cycle while m_tready is high
// s_tready drops while the queue has fewer than three free entries, so a
// stalled receiver backs up into the source once six entries are held
// reset: asynchronous, clears lexer state and empties the queue
module c_source_tokenizer #(
    parameter int POS_BITS = cst_pkg::POS_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // subcode, value, overflow, start_pos, length, zero pad
    output logic [3:0]  m_tuser    // kind
);

    localparam int CW = cst_pkg::FIFO_AW + 1;

    cst_pkg::mode_t        mode_reg, mode_next, mode_a;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [POS_BITS-1:0]   start_reg, start_next;
    logic [POS_BITS-1:0]   len_reg, len_next, len_a, len_inc;
    logic [63:0]           word_reg, word_next, word_a;
    logic [31:0]           acc_reg, acc_next, acc_a;
    logic                  ovf_reg, ovf_next, ovf_a;
    logic [7:0]            held_reg, held_next;
    logic [3:0]            cls_reg, cls_next, cls_a;

    logic [7:0]  cc, low;
    logic        is_dig, is_alpha, is_alnum, is_oct, is_hex;
    logic [3:0]  dval;
    logic [35:0] scaled, acc_sum;
    logic [5:0]  kw;
    logic [8:0]  esc;
    logic        consumed, do_suffix, do_tail;
    logic        a0_v, a1_v, b_v;
    cst_pkg::res_t a0, a1, b;
    cst_pkg::res_t items [3];
    logic [1:0]  n_items;

    cst_pkg::res_t fifo_reg [cst_pkg::FIFO_DEPTH];
    logic [cst_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          accept, pop;

    function automatic cst_pkg::res_t mk(logic [3:0] k, logic [7:0] s, logic [31:0] v,
                                         logic o, logic [POS_BITS-1:0] st,
                                         logic [POS_BITS-1:0] ln);
        cst_pkg::res_t r;
        r.kind      = k;
        r.subcode   = s;
        r.value     = v;
        r.overflow  = o;
        r.start_pos = cst_pkg::OUT_POS'(st);
        r.length    = cst_pkg::OUT_POS'(ln);
        return r;
    endfunction

    function automatic cst_pkg::res_t mk_op(logic [23:0] key, logic [POS_BITS-1:0] st,
                                            logic [POS_BITS-1:0] ln);
        logic [6:0] op;
        op = cst_pkg::op_lookup(key);
        if (op[6])
        begin
            return mk(cst_pkg::K_OP, {2'b00, op[5:0]}, 32'd0, 1'b0, st, ln);
        end
        return mk(cst_pkg::K_INVALID, 8'd0, 32'd0, 1'b0, st, ln);
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = count_reg <= CW'(cst_pkg::FIFO_ROOM);

    // character classes of the current byte
    assign cc       = s_tlast ? 8'h00 : s_tdata;
    assign low      = (cc >= "A" && cc <= "Z") ? cc + 8'd32 : cc;
    assign is_dig   = cc >= "0" && cc <= "9";
    assign is_alpha = low >= "a" && low <= "z";
    assign is_alnum = is_dig || is_alpha;
    assign is_oct   = cc >= "0" && cc <= "7";
    assign is_hex   = is_dig || (low >= "a" && low <= "f");
    assign dval     = is_dig ? cc[3:0] : low[3:0] + 4'd9;
    assign len_inc  = (len_reg == '1) ? len_reg : len_reg + POS_BITS'(1);
    assign kw       = cst_pkg::kw_lookup(word_reg);
    assign esc      = cst_pkg::escape_val(cc);

    // shift-add accumulation by 8, 10 or 16
    always_comb
    begin
        if (mode_reg == cst_pkg::M_DEC)
        begin
            scaled = 36'({acc_reg, 3'b000}) + 36'({acc_reg, 1'b0});
        end
        else if (mode_reg == cst_pkg::M_HEX0 || mode_reg == cst_pkg::M_HEX)
        begin
            scaled = 36'({acc_reg, 4'b0000});
        end
        else
        begin
            scaled = 36'({acc_reg, 3'b000});
        end
        acc_sum = scaled + 36'(dval);
    end

    // finish or extend the pending token
    always_comb
    begin
        mode_a    = mode_reg;
        len_a     = len_reg;
        acc_a     = acc_reg;
        ovf_a     = ovf_reg;
        cls_a     = cls_reg;
        word_a    = word_reg;
        consumed  = 1'b1;
        do_suffix = 1'b0;
        do_tail   = 1'b0;
        a0_v      = 1'b0;
        a1_v      = 1'b0;
        a0        = '0;
        a1        = '0;
        unique case (mode_reg)
            cst_pkg::M_IDLE:
            begin
                consumed = 1'b0;
            end
            cst_pkg::M_NAME:
            begin
                if (is_alnum || cc == "_")
                begin
                    if (len_reg < POS_BITS'(cst_pkg::KW_LEN))
                    begin
                        word_a = {word_reg[55:0], cc};
                    end
                    len_a  = len_inc;
                end
                else
                begin
                    a0_v     = 1'b1;
                    mode_a   = cst_pkg::M_IDLE;
                    consumed = 1'b0;
                    if (len_reg <= POS_BITS'(cst_pkg::KW_LEN) && word_reg == 64'("true"))
                    begin
                        a0 = mk(cst_pkg::K_BOOL, 8'd0, 32'd1, 1'b0, start_reg, len_reg);
                    end
                    else if (len_reg <= POS_BITS'(cst_pkg::KW_LEN)
                             && word_reg == 64'("false"))
                    begin
                        a0 = mk(cst_pkg::K_BOOL, 8'd0, 32'd0, 1'b0, start_reg, len_reg);
                    end
                    else if (len_reg <= POS_BITS'(cst_pkg::KW_LEN) && kw[5])
                    begin
                        a0 = mk(cst_pkg::K_KEYWORD, {3'b000, kw[4:0]}, 32'd0, 1'b0,
                                start_reg, len_reg);
                    end
                    else
                    begin
                        a0 = mk(cst_pkg::K_NAME, 8'd0, 32'd0, 1'b0, start_reg, len_reg);
                    end
                end
            end
            cst_pkg::M_ZERO, cst_pkg::M_DEC, cst_pkg::M_OCT:
            begin
                if (mode_reg == cst_pkg::M_ZERO && low == "x")
                begin
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_HEX0;
                end
                else if ((mode_reg == cst_pkg::M_DEC) ? is_dig : is_oct)
                begin
                    acc_a  = acc_sum[31:0];
                    ovf_a  = ovf_reg || (acc_sum[35:32] != 4'd0);
                    len_a  = len_inc;
                    mode_a = (mode_reg == cst_pkg::M_DEC) ? cst_pkg::M_DEC : cst_pkg::M_OCT;
                end
                else if (mode_reg != cst_pkg::M_OCT && cc == ".")
                begin
                    cls_a  = cst_pkg::CL_DB;
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_DOT;
                end
                else if (mode_reg != cst_pkg::M_OCT && cc == "e")
                begin
                    cls_a  = cst_pkg::CL_DB;
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_EXP0;
                end
                else
                begin
                    do_suffix = 1'b1;
                end
            end
            cst_pkg::M_HEX0, cst_pkg::M_HEX:
            begin
                if (is_hex)
                begin
                    acc_a  = acc_sum[31:0];
                    ovf_a  = ovf_reg || (acc_sum[35:32] != 4'd0);
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_HEX;
                end
                else if (mode_reg == cst_pkg::M_HEX0)
                begin
                    a0_v     = 1'b1;
                    a0       = mk(cst_pkg::K_INVALID, 8'd0, 32'd0, 1'b0, start_reg, len_reg);
                    mode_a   = cst_pkg::M_IDLE;
                    consumed = 1'b0;
                end
                else
                begin
                    do_suffix = 1'b1;
                end
            end
            cst_pkg::M_DOT, cst_pkg::M_EXP0, cst_pkg::M_BAD:
            begin
                if (mode_reg == cst_pkg::M_BAD ? is_alnum : is_dig)
                begin
                    len_a = len_inc;
                    unique case (mode_reg)
                        cst_pkg::M_DOT:  mode_a = cst_pkg::M_FRAC;
                        cst_pkg::M_EXP0: mode_a = cst_pkg::M_EXP;
                        default:         mode_a = cst_pkg::M_BAD;
                    endcase
                end
                else
                begin
                    a0_v     = 1'b1;
                    a0       = mk(cst_pkg::K_INVALID, 8'd0, 32'd0, 1'b0, start_reg, len_reg);
                    mode_a   = cst_pkg::M_IDLE;
                    consumed = 1'b0;
                end
            end
            cst_pkg::M_FRAC, cst_pkg::M_EXP:
            begin
                if (is_dig)
                begin
                    len_a = len_inc;
                end
                else if (mode_reg == cst_pkg::M_FRAC && cc == "e")
                begin
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_EXP0;
                end
                else
                begin
                    do_suffix = 1'b1;
                end
            end
            cst_pkg::M_SUF_U, cst_pkg::M_SUF_UL, cst_pkg::M_SUF_L:
            begin
                if (low == "l")
                begin
                    len_a = len_inc;
                    unique case (mode_reg)
                        cst_pkg::M_SUF_U:
                        begin
                            cls_a  = cst_pkg::CL_UL;
                            mode_a = cst_pkg::M_SUF_UL;
                        end
                        cst_pkg::M_SUF_UL:
                        begin
                            cls_a  = cst_pkg::CL_ULL;
                            mode_a = cst_pkg::M_TAIL;
                        end
                        default:
                        begin
                            cls_a  = cst_pkg::CL_LL;
                            mode_a = cst_pkg::M_TAIL;
                        end
                    endcase
                end
                else
                begin
                    do_tail = 1'b1;
                end
            end
            cst_pkg::M_SUF_FL:
            begin
                if (low == "d")
                begin
                    cls_a  = cst_pkg::CL_LDB;
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_TAIL;
                end
                else if (is_alnum)
                begin
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_BAD;
                end
                else
                begin
                    a0_v     = 1'b1;
                    a0       = mk(cst_pkg::K_INVALID, 8'd0, 32'd0, 1'b0, start_reg, len_reg);
                    mode_a   = cst_pkg::M_IDLE;
                    consumed = 1'b0;
                end
            end
            cst_pkg::M_TAIL:
            begin
                do_tail = 1'b1;
            end
            cst_pkg::M_CH_OPEN, cst_pkg::M_CH_ESC, cst_pkg::M_STR, cst_pkg::M_STR_ESC:
            begin
                if (s_tlast)
                begin
                    a0_v     = 1'b1;
                    a0       = mk(cst_pkg::K_INVALID, 8'd0, 32'd0, 1'b0, start_reg, len_reg);
                    mode_a   = cst_pkg::M_IDLE;
                    consumed = 1'b0;
                end
                else
                begin
                    len_a = len_inc;
                    unique case (mode_reg)
                        cst_pkg::M_CH_OPEN:
                        begin
                            if (cc == 8'h5c)
                            begin
                                mode_a = cst_pkg::M_CH_ESC;
                            end
                            else
                            begin
                                acc_a  = 32'(cc);
                                mode_a = cst_pkg::M_CH_CLOSE;
                            end
                        end
                        cst_pkg::M_CH_ESC:
                        begin
                            mode_a = cst_pkg::M_CH_CLOSE;
                            acc_a  = 32'(esc[7:0]);
                            if (!esc[8])
                            begin
                                a0_v   = 1'b1;
                                a0     = mk(cst_pkg::K_INVALID, 8'd0, 32'd0, 1'b0,
                                            start_reg, len_inc);
                                mode_a = cst_pkg::M_IDLE;
                            end
                        end
                        cst_pkg::M_STR:
                        begin
                            if (cc == 8'h22)
                            begin
                                a0_v   = 1'b1;
                                a0     = mk(cst_pkg::K_STRING, 8'd0, 32'd0, 1'b0,
                                            start_reg, len_inc);
                                mode_a = cst_pkg::M_IDLE;
                            end
                            else
                            begin
                                mode_a = (cc == 8'h5c) ? cst_pkg::M_STR_ESC : cst_pkg::M_STR;
                            end
                        end
                        default:
                        begin
                            mode_a = cst_pkg::M_STR;
                            if (!esc[8])
                            begin
                                a0_v   = 1'b1;
                                a0     = mk(cst_pkg::K_INVALID, 8'd0, 32'd0, 1'b0,
                                            start_reg, len_inc);
                                mode_a = cst_pkg::M_IDLE;
                            end
                        end
                    endcase
                end
            end
            cst_pkg::M_CH_CLOSE:
            begin
                a0_v   = 1'b1;
                mode_a = cst_pkg::M_IDLE;
                if (cc == 8'h27 && !s_tlast)
                begin
                    len_a = len_inc;
                    a0    = mk(cst_pkg::K_CHAR, 8'd0, acc_reg, 1'b0, start_reg, len_inc);
                end
                else
                begin
                    a0       = mk(cst_pkg::K_INVALID, 8'd0, 32'd0, 1'b0, start_reg, len_reg);
                    consumed = 1'b0;
                end
            end
            cst_pkg::M_OP1:
            begin
                if (cst_pkg::pair_ok(held_reg, cc))
                begin
                    len_a = len_inc;
                    if ((held_reg == "<" || held_reg == ">") && cc == held_reg)
                    begin
                        mode_a = cst_pkg::M_OP2;
                    end
                    else
                    begin
                        a0_v   = 1'b1;
                        a0     = mk_op({held_reg, cc, 8'h00}, start_reg, POS_BITS'(2));
                        mode_a = cst_pkg::M_IDLE;
                    end
                end
                else
                begin
                    a0_v     = 1'b1;
                    a0       = mk_op({held_reg, 16'h0000}, start_reg, POS_BITS'(1));
                    mode_a   = cst_pkg::M_IDLE;
                    consumed = 1'b0;
                end
            end
            cst_pkg::M_OP2:
            begin
                a0_v   = 1'b1;
                mode_a = cst_pkg::M_IDLE;
                if (cc == "=")
                begin
                    len_a = len_inc;
                    a0    = mk_op({held_reg, held_reg, "="}, start_reg, POS_BITS'(3));
                end
                else
                begin
                    a0       = mk_op({held_reg, held_reg, 8'h00}, start_reg, POS_BITS'(2));
                    consumed = 1'b0;
                end
            end
            cst_pkg::M_DOT1:
            begin
                if (cc == ".")
                begin
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_DOT2;
                end
                else
                begin
                    a0_v     = 1'b1;
                    a0       = mk_op({".", 16'h0000}, start_reg, POS_BITS'(1));
                    mode_a   = cst_pkg::M_IDLE;
                    consumed = 1'b0;
                end
            end
            cst_pkg::M_DOT2:
            begin
                a0_v   = 1'b1;
                mode_a = cst_pkg::M_IDLE;
                if (cc == ".")
                begin
                    len_a = len_inc;
                    a0    = mk(cst_pkg::K_VARARGS, 8'd0, 32'd0, 1'b0, start_reg, len_inc);
                end
                else
                begin
                    // two dots that are not varargs split into two operators
                    a1_v     = 1'b1;
                    a0       = mk_op({".", 16'h0000}, start_reg, POS_BITS'(1));
                    a1       = mk_op({".", 16'h0000}, start_reg + POS_BITS'(1),
                                     POS_BITS'(1));
                    consumed = 1'b0;
                end
            end
            default:
            begin
                mode_a   = cst_pkg::M_IDLE;
                consumed = 1'b0;
            end
        endcase

        if (do_suffix)
        begin
            if (cls_reg == cst_pkg::CL_DB)
            begin
                if (low == "f")
                begin
                    cls_a  = cst_pkg::CL_F;
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_TAIL;
                end
                else if (low == "l")
                begin
                    len_a  = len_inc;
                    mode_a = cst_pkg::M_SUF_FL;
                end
                else
                begin
                    do_tail = 1'b1;
                end
            end
            else if (low == "u")
            begin
                cls_a  = cst_pkg::CL_U;
                len_a  = len_inc;
                mode_a = cst_pkg::M_SUF_U;
            end
            else if (low == "l")
            begin
                cls_a  = cst_pkg::CL_L;
                len_a  = len_inc;
                mode_a = cst_pkg::M_SUF_L;
            end
            else
            begin
                do_tail = 1'b1;
            end
        end

        if (do_tail)
        begin
            if (is_alnum)
            begin
                len_a  = len_inc;
                mode_a = cst_pkg::M_BAD;
            end
            else
            begin
                a0_v     = 1'b1;
                mode_a   = cst_pkg::M_IDLE;
                consumed = 1'b0;
                if (cls_reg >= cst_pkg::CL_F)
                begin
                    a0 = mk(cst_pkg::K_FLOAT, {4'b0000, cls_reg}, 32'd0, 1'b0,
                            start_reg, len_reg);
                end
                else
                begin
                    a0 = mk(cst_pkg::K_INT, {4'b0000, cls_reg}, acc_reg, ovf_reg,
                            start_reg, len_reg);
                end
            end
        end
    end

    // start a new token on an unconsumed byte, or close the text
    always_comb
    begin
        mode_next  = mode_a;
        len_next   = len_a;
        acc_next   = acc_a;
        ovf_next   = ovf_a;
        cls_next   = cls_a;
        word_next  = word_a;
        start_next = start_reg;
        held_next  = held_reg;
        pos_next   = pos_reg + POS_BITS'(1);
        b_v        = 1'b0;
        b          = '0;
        if (s_tlast)
        begin
            b_v        = 1'b1;
            b          = mk(cst_pkg::K_EOF, 8'd0, 32'd0, 1'b0, pos_reg, '0);
            mode_next  = cst_pkg::M_IDLE;
            len_next   = '0;
            acc_next   = '0;
            ovf_next   = 1'b0;
            cls_next   = cst_pkg::CL_I;
            word_next  = '0;
            start_next = '0;
            held_next  = '0;
            pos_next   = '0;
        end
        else if (!consumed)
        begin
            start_next = pos_reg;
            len_next   = POS_BITS'(1);
            acc_next   = '0;
            ovf_next   = 1'b0;
            cls_next   = cst_pkg::CL_I;
            if (cc == " " || (cc >= 8'd9 && cc <= 8'd13))
            begin
                mode_next = cst_pkg::M_IDLE;
            end
            else if (is_dig)
            begin
                acc_next  = 32'(cc[3:0]);
                mode_next = (cc == "0") ? cst_pkg::M_ZERO : cst_pkg::M_DEC;
            end
            else if (is_alpha || cc == "_")
            begin
                word_next = {56'd0, cc};
                mode_next = cst_pkg::M_NAME;
            end
            else if (cc == 8'h27)
            begin
                mode_next = cst_pkg::M_CH_OPEN;
            end
            else if (cc == 8'h22)
            begin
                mode_next = cst_pkg::M_STR;
            end
            else if (cc == "(" || cc == ")" || cc == "{" || cc == "}" || cc == "["
                     || cc == "]" || cc == ";" || cc == ",")
            begin
                b_v = 1'b1;
                b   = mk(cst_pkg::K_PUNCT, cc, 32'd0, 1'b0, pos_reg, POS_BITS'(1));
            end
            else if (cc == "?" || cc == ":" || cc == "~")
            begin
                b_v = 1'b1;
                b   = mk_op({cc, 16'h0000}, pos_reg, POS_BITS'(1));
            end
            else if (cc == ".")
            begin
                mode_next = cst_pkg::M_DOT1;
            end
            else if (cc == "&" || cc == "|" || cc == "+" || cc == "-" || cc == "="
                     || cc == ">" || cc == "<" || cc == "!" || cc == "^" || cc == "%"
                     || cc == "/" || cc == "*")
            begin
                held_next = cc;
                mode_next = cst_pkg::M_OP1;
            end
            else
            begin
                b_v = 1'b1;
                b   = mk(cst_pkg::K_INVALID, 8'd0, 32'd0, 1'b0, pos_reg, POS_BITS'(1));
            end
        end
    end

    // pack results of this beat in order
    always_comb
    begin
        items[0] = a0;
        items[1] = a1;
        items[2] = b;
        n_items  = 2'd0;
        if (a0_v)
        begin
            n_items = a1_v ? 2'd2 : 2'd1;
        end
        if (b_v)
        begin
            items[n_items] = b;
            n_items        = n_items + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= cst_pkg::M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            word_reg  <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            held_reg  <= '0;
            cls_reg   <= cst_pkg::CL_I;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            word_reg  <= word_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            held_reg  <= held_next;
            cls_reg   <= cls_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + cst_pkg::FIFO_AW'(n_items);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + cst_pkg::FIFO_AW'(1);
            end
            count_reg <= count_reg + (accept ? CW'(n_items) : CW'(0)) - CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (i < int'(n_items))
                begin
                    fifo_reg[wr_ptr_reg + cst_pkg::FIFO_AW'(i)] <= items[i];
                end
            end
        end
    end

    assign m_tvalid = count_reg != '0;
    assign m_tuser  = fifo_reg[rd_ptr_reg].kind;
    assign m_tdata  = {7'd0, fifo_reg[rd_ptr_reg].length, fifo_reg[rd_ptr_reg].start_pos,
                       fifo_reg[rd_ptr_reg].overflow, fifo_reg[rd_ptr_reg].value,
                       fifo_reg[rd_ptr_reg].subcode};

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(cst_pkg::FIFO_DEPTH))
        else $error("result queue over capacity");

    a_eof_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> count_reg != '0)
        else $error("end of text produced no token");

    a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> mode_reg == cst_pkg::M_IDLE && pos_reg == '0)
        else $error("lexer state not cleared after end of text");

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_tlast |=> pos_reg == $past(pos_reg) + POS_BITS'(1))
        else $error("byte position did not advance");

endmodule
